// ===== rtl/fcr_pkg.sv =====
// Shared types and constants for the frame checksum realigner.
package fcr_pkg;

   // Largest frame the buffer holds by default.
   localparam int MAX_FRAME_LEN_DEF = 64;

   // Register reset values.
   localparam logic [6:0] FRAME_LENGTH_RST = 7'd31;
   localparam logic [7:0] HEADER_BYTE_RST  = 8'd194;
   localparam logic [3:0] MAX_REALIGN_RST  = 4'd3;
   localparam logic       STREAM_MODE_RST  = 1'b1;

   // Smallest usable frame: one data byte and two checksum bytes.
   localparam int MIN_FRAME_LEN = 3;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_FRAME_LENGTH = 2'd0,
      REG_HEADER_BYTE  = 2'd1,
      REG_MAX_REALIGN  = 2'd2,
      REG_STREAM_MODE  = 2'd3
   } reg_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BAD_SUM      = 2'd1,
      ST_BAD_HEADER   = 2'd2,
      ST_REALIGN_FAIL = 2'd3
   } status_type;

   // Sequencer states: each buffer access has an address step (_A) and a
   // data step (_D) because the buffer read is registered.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM_A,
      S_SUM_D,
      S_TRH_A,
      S_TRH_D,
      S_TRL_A,
      S_TRL_D,
      S_HDR_A,
      S_HDR_D,
      S_SCAN_A,
      S_SCAN_D,
      S_SHF_A,
      S_SHF_D,
      S_EMIT_A,
      S_EMIT_D,
      S_ERR
   } state_type;

endpackage

// ===== rtl/fcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/frame_checksum_realigner.sv =====
// Top level: fixed-length frame sync with 16-bit additive checksum and realignment.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   req     | in        | req_valid / req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_out_byte, rsp_byte_index,
//           |           |                        | rsp_last, rsp_status
//   csr     | in        | APB write (psel..)     | paddr, pwdata / prdata
//
// A byte that does not complete a frame is only stored. The byte that completes a
// frame of L bytes starts a walk of the frame buffer through its one read port,
// each access an address step and a data step: bytes 0 .. L-3 for the checksum,
// the two trailer bytes, the header, then the L bytes of a good frame (held by any
// rsp stall), or a scan for the header at offset M and a shift of the buffer by M.
// reset is synchronous and clears control state and registers; the buffer itself
// is not cleared. req_stall is high for the whole walk; rsp results sit in an
// output register, so a stalled last result does not block the next req transfer.
module frame_checksum_realigner #(
   parameter int MAX_FRAME_LEN = fcr_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import fcr_pkg::*;

   // AW addresses the buffer; CW holds a count up to the buffer depth itself.
   localparam int AW = $clog2(MAX_FRAME_LEN);
   localparam int CW = $clog2(MAX_FRAME_LEN + 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [6:0] frame_length_ff;
   logic [7:0] header_byte_ff;
   logic [3:0] max_realign_ff;
   logic       stream_mode_ff;
   logic       cfg_write;
   reg_index_type cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RST;
         header_byte_ff  <= HEADER_BYTE_RST;
         max_realign_ff  <= MAX_REALIGN_RST;
         stream_mode_ff  <= STREAM_MODE_RST;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_FRAME_LENGTH: frame_length_ff <= pwdata[6:0];
            REG_HEADER_BYTE:  header_byte_ff  <= pwdata[7:0];
            REG_MAX_REALIGN:  max_realign_ff  <= pwdata[3:0];
            REG_STREAM_MODE:  stream_mode_ff  <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_FRAME_LENGTH: prdata = {25'd0, frame_length_ff};
         REG_HEADER_BYTE:  prdata = {24'd0, header_byte_ff};
         REG_MAX_REALIGN:  prdata = {28'd0, max_realign_ff};
         REG_STREAM_MODE:  prdata = {31'd0, stream_mode_ff};
      endcase
   end

   // Effective frame length: clamp to the usable range of the buffer.
   logic [8:0]    len_wide;
   logic [CW-1:0] len;

   always_comb begin
      if (frame_length_ff < 7'(MIN_FRAME_LEN)) begin
         len_wide = 9'(MIN_FRAME_LEN);
      end else if (9'(frame_length_ff) > 9'(MAX_FRAME_LEN)) begin
         len_wide = 9'(MAX_FRAME_LEN);
      end else begin
         len_wide = 9'(frame_length_ff);
      end
   end

   assign len = CW'(len_wide);

   // ---------------------------------------------------------------------
   // Frame buffer
   // ---------------------------------------------------------------------
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   fcr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME_LEN)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;      // bytes buffered
   logic [3:0]    trial_ff, trial_in;    // realignments on this frame
   logic [CW-1:0] idx_ff, idx_in;        // walk position
   logic [CW-1:0] miss_ff, miss_in;      // header offset found by the scan
   logic [15:0]   sum_ff, sum_in;        // running checksum
   logic [7:0]    trl_hi_ff, trl_hi_in;  // high trailer byte
   status_type    err_ff, err_in;        // pending error code

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [5:0]    rsp_index_ff, rsp_index_in;
   logic          rsp_last_ff, rsp_last_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          req_take;
   logic          out_free;
   logic          out_load;
   logic [CW-1:0] fill_next;
   logic [CW-1:0] shf_addr;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign fill_next = fill_ff + CW'(1);
   assign shf_addr  = idx_ff + miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         trial_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         trial_ff     <= trial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      miss_ff       <= miss_in;
      sum_ff        <= sum_in;
      trl_hi_ff     <= trl_hi_in;
      err_ff        <= err_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      trial_in      = trial_ff;
      idx_in        = idx_ff;
      miss_in       = miss_ff;
      sum_in        = sum_ff;
      trl_hi_in     = trl_hi_ff;
      err_in        = err_ff;
      ram_we        = 1'b0;
      ram_waddr     = fill_ff[AW-1:0];
      ram_wdata     = req_rx_byte;
      ram_raddr     = '0;
      out_load      = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Store the byte; a full frame starts the checksum walk.
            if (req_take) begin
               ram_we  = 1'b1;
               fill_in = fill_next;
               if (fill_next >= len) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = S_SUM_A;
               end
            end
         end

         S_SUM_A: begin
            ram_raddr = idx_ff[AW-1:0];
            state_in  = S_SUM_D;
         end

         S_SUM_D: begin
            // Accumulate bytes 0 .. len-3.
            ram_raddr = idx_ff[AW-1:0];
            sum_in    = sum_ff + 16'(ram_rdata);
            if (idx_ff + CW'(3) == len) begin
               state_in = S_TRH_A;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SUM_A;
            end
         end

         S_TRH_A: begin
            ram_raddr = AW'(len - CW'(2));
            state_in  = S_TRH_D;
         end

         S_TRH_D: begin
            ram_raddr = AW'(len - CW'(2));
            trl_hi_in = ram_rdata;
            state_in  = S_TRL_A;
         end

         S_TRL_A: begin
            ram_raddr = AW'(len - CW'(1));
            state_in  = S_TRL_D;
         end

         S_TRL_D: begin
            // Compare the big-endian trailer, then pick the next step.
            ram_raddr = AW'(len - CW'(1));
            priority if ({trl_hi_ff, ram_rdata} == sum_ff) begin
               state_in = S_HDR_A;
            end else if (!stream_mode_ff) begin
               err_in   = ST_BAD_SUM;
               state_in = S_ERR;
            end else if (trial_ff >= max_realign_ff) begin
               err_in   = ST_REALIGN_FAIL;
               state_in = S_ERR;
            end else begin
               idx_in   = CW'(1);
               state_in = S_SCAN_A;
            end
         end

         S_HDR_A: begin
            state_in = S_HDR_D;
         end

         S_HDR_D: begin
            if (ram_rdata != header_byte_ff) begin
               err_in   = ST_BAD_HEADER;
               state_in = S_ERR;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT_A;
            end
         end

         S_SCAN_A: begin
            ram_raddr = idx_ff[AW-1:0];
            state_in  = S_SCAN_D;
         end

         S_SCAN_D: begin
            // Look for the header at offsets 1 .. len-1.
            ram_raddr = idx_ff[AW-1:0];
            priority if (ram_rdata == header_byte_ff) begin
               miss_in  = idx_ff;
               idx_in   = '0;
               state_in = S_SHF_A;
            end else if (idx_ff + CW'(1) == len) begin
               err_in   = ST_REALIGN_FAIL;
               state_in = S_ERR;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN_A;
            end
         end

         S_SHF_A: begin
            ram_raddr = shf_addr[AW-1:0];
            state_in  = S_SHF_D;
         end

         S_SHF_D: begin
            // Move byte idx+miss down to idx; the read stays ahead of the write.
            ram_raddr = shf_addr[AW-1:0];
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            if (shf_addr + CW'(1) == len) begin
               fill_in  = len - miss_ff;
               trial_in = trial_ff + 4'd1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SHF_A;
            end
         end

         S_EMIT_A: begin
            ram_raddr = idx_ff[AW-1:0];
            state_in  = S_EMIT_D;
         end

         S_EMIT_D: begin
            // Hold the read address so the byte waits until the output is free.
            ram_raddr = idx_ff[AW-1:0];
            if (out_free) begin
               out_load      = 1'b1;
               rsp_byte_in   = ram_rdata;
               rsp_index_in  = 6'(idx_ff);
               rsp_last_in   = (idx_ff + CW'(1) == len);
               rsp_status_in = ST_OK;
               if (idx_ff + CW'(1) == len) begin
                  fill_in  = '0;
                  trial_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_EMIT_A;
               end
            end
         end

         S_ERR: begin
            // Single error result; drop the buffer.
            if (out_free) begin
               out_load      = 1'b1;
               rsp_byte_in   = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = err_ff;
               fill_in       = '0;
               trial_in      = '0;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
